FILE: rtl/battery_level_filter_macros.svh
// assertion helpers for the battery level filter
`ifndef BATTERY_LEVEL_FILTER_MACROS_SVH
`define BATTERY_LEVEL_FILTER_MACROS_SVH

// condition holds at every clock edge out of reset
`define BLF_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define BLF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define BLF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/blf_pkg.sv
package blf_pkg;

    localparam int MEDIAN_TAPS = 5;
    localparam int MEAN_TAPS   = 8;

    localparam int ADC_W = 12;
    localparam int PCT_W = 7;
    localparam int CFG_IDX_W = 2;

    localparam int MED_IW = (MEDIAN_TAPS > 1) ? $clog2(MEDIAN_TAPS) : 1;
    localparam int MED_CW = $clog2(MEDIAN_TAPS + 1);
    localparam int MEAN_IW = (MEAN_TAPS > 1) ? $clog2(MEAN_TAPS) : 1;
    localparam int MEAN_CW = $clog2(MEAN_TAPS + 1);
    localparam int SUM_W = PCT_W + $clog2(MEAN_TAPS);

    // shared divider geometry
    localparam int DIV_NUM_W = 12;
    localparam int DIV_DEN_W = 7;
    localparam int DIV_QUO_W = 7;
    localparam int DIV_SH_W  = DIV_DEN_W + DIV_QUO_W - 1;
    localparam int DIV_CNT_W = $clog2(DIV_QUO_W);

    localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(100);

    // converter breakpoints
    localparam logic [ADC_W-1:0] ADC_BP0 = ADC_W'(2951);
    localparam logic [ADC_W-1:0] ADC_BP1 = ADC_W'(3019);
    localparam logic [ADC_W-1:0] ADC_BP2 = ADC_W'(3037);
    localparam logic [ADC_W-1:0] ADC_BP3 = ADC_W'(3091);
    localparam logic [ADC_W-1:0] ADC_BP4 = ADC_W'(3124);
    localparam logic [ADC_W-1:0] ADC_BP5 = ADC_W'(3231);

    // register reset values and indexes
    localparam logic [PCT_W-1:0] RST_LOW_THR = PCT_W'(15);
    localparam logic [PCT_W-1:0] RST_CHG_STEP = PCT_W'(5);
    localparam logic [PCT_W-1:0] RST_DIS_STEP = PCT_W'(2);

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CHG_STEP = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_DIS_STEP = CFG_IDX_W'(2);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAP,
        S_DIV_RAW,
        S_INS,
        S_MED,
        S_MINS,
        S_SUM,
        S_MEAN_GO,
        S_DIV_MEAN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_QUO_W-1:0] quo;
    } t_div_rsp;

    // lower breakpoint of a segment
    function automatic logic [ADC_W-1:0] seg_base(input logic [2:0] seg);
        logic [ADC_W-1:0] v;
        case (seg)
            3'd0: v = ADC_BP0;
            3'd1: v = ADC_BP1;
            3'd2: v = ADC_BP2;
            3'd3: v = ADC_BP3;
            3'd4: v = ADC_BP4;
            default: v = ADC_BP0;
        endcase
        return v;
    endfunction

    // width of a segment in converter counts
    function automatic logic [DIV_DEN_W-1:0] seg_span(input logic [2:0] seg);
        logic [DIV_DEN_W-1:0] v;
        case (seg)
            3'd0: v = DIV_DEN_W'(ADC_BP1 - ADC_BP0);
            3'd1: v = DIV_DEN_W'(ADC_BP2 - ADC_BP1);
            3'd2: v = DIV_DEN_W'(ADC_BP3 - ADC_BP2);
            3'd3: v = DIV_DEN_W'(ADC_BP4 - ADC_BP3);
            3'd4: v = DIV_DEN_W'(ADC_BP5 - ADC_BP4);
            default: v = DIV_DEN_W'(ADC_BP1 - ADC_BP0);
        endcase
        return v;
    endfunction

    // percentage at the lower breakpoint of a segment
    function automatic logic [PCT_W-1:0] seg_pct(input logic [2:0] seg);
        logic [PCT_W-1:0] v;
        case (seg)
            3'd0: v = PCT_W'(0);
            3'd1: v = PCT_W'(20);
            3'd2: v = PCT_W'(40);
            3'd3: v = PCT_W'(60);
            3'd4: v = PCT_W'(80);
            default: v = PCT_W'(0);
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/blf_div.sv
module blf_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  blf_pkg::t_div_req i_req,
    output blf_pkg::t_div_rsp o_rsp
);
    import blf_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_NUM_W-1:0] r_rem;
    logic [DIV_SH_W-1:0]  r_dsh;
    logic [DIV_QUO_W-1:0] r_q;

    logic [DIV_SH_W-1:0]  rem_ext;
    logic                 fits;

    // one restoring step per cycle
    assign rem_ext = DIV_SH_W'(r_rem);
    assign fits    = (rem_ext >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == DIV_CNT_W'(DIV_QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.num;
            r_dsh <= {i_req.den, {(DIV_QUO_W - 1){1'b0}}};
            r_q   <= '0;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= DIV_NUM_W'(rem_ext - r_dsh);
            end
            r_q   <= {r_q[DIV_QUO_W-2:0], fits};
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;

endmodule

FILE: rtl/battery_level_filter.sv
// a result follows input acceptance through the segment map, a divider pass unless the
// level is clamped, the median rank scan, the mean sum, the mean divider pass and any
// wait for a result still stalled in the output register
// one transaction is processed at a time; the next one is taken while the registered
// result may still wait on a stalled output
// reset (synchronous, active low): windows empty, registers 15/5/2, first pending
module battery_level_filter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [blf_pkg::ADC_W-1:0]     i_adc_level,
    input  logic                          i_charging,
    // output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [blf_pkg::PCT_W-1:0]     o_display_pct,
    output logic [blf_pkg::PCT_W-1:0]     o_average_pct,
    output logic                          o_low_battery,
    output logic                          o_changed,
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic [blf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [blf_pkg::PCT_W-1:0]     i_cfg_data
);
    import blf_pkg::*;

    // sequencer
    t_state r_state, n_state;

    // configuration registers
    logic [PCT_W-1:0] r_low_thr, r_chg_step, r_dis_step;

    // captured transaction
    logic [ADC_W-1:0] r_adc;
    logic             r_chg;

    // mapping and median
    logic [PCT_W-1:0]  r_base;
    logic [PCT_W-1:0]  r_raw;
    logic [PCT_W-1:0]  r_med_win [MEDIAN_TAPS];
    logic [MED_IW-1:0] r_med_wpos;
    logic [MED_CW-1:0] r_med_fill;
    logic [MED_IW-1:0] r_i, r_j;
    logic [MED_CW-1:0] r_cnt_lt, r_cnt_le;
    logic [PCT_W-1:0]  r_med;

    // mean
    logic [PCT_W-1:0]   r_mean_win [MEAN_TAPS];
    logic [MEAN_IW-1:0] r_mean_wpos;
    logic [MEAN_CW-1:0] r_mean_fill;
    logic [MEAN_IW-1:0] r_idx;
    logic [SUM_W-1:0]   r_sum;
    logic [PCT_W-1:0]   r_filt;

    // display state
    logic             r_first;
    logic [PCT_W-1:0] r_shown;
    logic             r_last_chg;
    logic             r_last_low;

    // output register
    logic             r_out_valid;
    logic [PCT_W-1:0] r_out_disp;
    logic [PCT_W-1:0] r_out_filt;
    logic             r_out_low;
    logic             r_out_changed;

    // shared divider
    t_div_req div_req;
    t_div_rsp div_rsp;

    blf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // control decode
    // ------------------------------------------------------------------
    logic in_acc;
    logic out_free;
    logic map_lo, map_hi;
    logic [2:0] seg;
    logic [ADC_W-1:0] off;
    logic [DIV_NUM_W-1:0] off_x20;

    logic [PCT_W-1:0]  cand, ent;
    logic [MED_CW-1:0] cnt_lt_n, cnt_le_n, med_k;
    logic              med_row_end, med_hit;
    logic              sum_end;

    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;

    // segment lookup over the breakpoint table
    assign map_lo = (r_adc <= ADC_BP0);
    assign map_hi = (r_adc >= ADC_BP5);

    always_comb begin
        seg = 3'd0;
        if (r_adc >= ADC_BP1) seg = 3'd1;
        if (r_adc >= ADC_BP2) seg = 3'd2;
        if (r_adc >= ADC_BP3) seg = 3'd3;
        if (r_adc >= ADC_BP4) seg = 3'd4;
    end

    // offset times the 20 point rise of every segment
    assign off     = r_adc - seg_base(seg);
    assign off_x20 = DIV_NUM_W'({off, 4'b0000}) + DIV_NUM_W'({off, 2'b00});

    // median by rank: candidate i against entry j, one compare per cycle
    assign cand        = r_med_win[r_i];
    assign ent         = r_med_win[r_j];
    assign cnt_lt_n    = r_cnt_lt + MED_CW'(ent < cand);
    assign cnt_le_n    = r_cnt_le + MED_CW'(ent <= cand);
    assign med_k       = r_med_fill >> 1;
    assign med_row_end = (MED_CW'(r_j) == r_med_fill - 1'b1);
    assign med_hit     = ((cnt_lt_n <= med_k) && (med_k < cnt_le_n))
                         || (MED_CW'(r_i) == r_med_fill - 1'b1);

    assign sum_end = (MEAN_CW'(r_idx) == r_mean_fill - 1'b1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (in_acc) n_state = S_MAP;
            S_MAP:      n_state = (map_lo || map_hi) ? S_INS : S_DIV_RAW;
            S_DIV_RAW:  if (div_rsp.done) n_state = S_INS;
            S_INS:      n_state = S_MED;
            S_MED:      if (med_row_end && med_hit) n_state = S_MINS;
            S_MINS:     n_state = S_SUM;
            S_SUM:      if (sum_end) n_state = S_MEAN_GO;
            S_MEAN_GO:  n_state = S_DIV_MEAN;
            S_DIV_MEAN: if (div_rsp.done) n_state = S_OUT;
            S_OUT:      if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // state outputs: stall and divider requests
    always_comb begin
        o_stall       = 1'b1;
        div_req.start = 1'b0;
        div_req.num   = off_x20;
        div_req.den   = seg_span(seg);
        case (r_state)
            S_IDLE: o_stall = 1'b0;
            S_MAP:  div_req.start = !(map_lo || map_hi);
            S_MEAN_GO: begin
                div_req.start = 1'b1;
                div_req.num   = DIV_NUM_W'(r_sum);
                div_req.den   = DIV_DEN_W'(r_mean_fill);
            end
            default: o_stall = 1'b1;
        endcase
    end

    // ------------------------------------------------------------------
    // display step limits
    // ------------------------------------------------------------------
    logic [PCT_W:0]   shown8, filt8, cs8, up8;
    logic [PCT_W-1:0] target, drop;
    logic [PCT_W-1:0] disp;
    logic             low;
    logic             changed;

    always_comb begin
        shown8 = {1'b0, r_shown};
        filt8  = {1'b0, r_filt};
        cs8    = {1'b0, r_chg_step};
        up8    = shown8 + cs8;
        target = (r_filt < r_shown) ? r_filt : r_shown;
        drop   = r_shown - target;
        if (r_first) begin
            disp = r_filt;
        end else if (r_chg) begin
            if (filt8 > up8) begin
                // climbing while charging, limited and clamped to full
                disp = (up8 > {1'b0, PCT_MAX}) ? PCT_MAX : up8[PCT_W-1:0];
            end else if ((filt8 + cs8) < shown8) begin
                disp = r_shown - r_chg_step;
            end else begin
                disp = r_filt;
            end
        end else begin
            // discharging never rises
            disp = (drop > r_dis_step) ? (r_shown - r_dis_step) : target;
        end
        low     = (disp <= r_low_thr) && !r_chg;
        changed = (disp != r_shown) || (r_chg != r_last_chg) || (low != r_last_low);
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_low_thr   <= RST_LOW_THR;
            r_chg_step  <= RST_CHG_STEP;
            r_dis_step  <= RST_DIS_STEP;
            r_med_wpos  <= '0;
            r_med_fill  <= '0;
            r_mean_wpos <= '0;
            r_mean_fill <= '0;
            r_first     <= 1'b1;
            r_shown     <= '0;
            r_last_chg  <= 1'b0;
            r_last_low  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LOW_THR:  r_low_thr  <= i_cfg_data;
                    CFG_CHG_STEP: r_chg_step <= i_cfg_data;
                    CFG_DIS_STEP: r_dis_step <= i_cfg_data;
                    default:      ;
                endcase
            end

            if (r_state == S_INS) begin
                r_med_wpos <= (r_med_wpos == MED_IW'(MEDIAN_TAPS - 1))
                              ? '0 : r_med_wpos + 1'b1;
                if (r_med_fill != MED_CW'(MEDIAN_TAPS)) r_med_fill <= r_med_fill + 1'b1;
            end

            if (r_state == S_MINS) begin
                r_mean_wpos <= (r_mean_wpos == MEAN_IW'(MEAN_TAPS - 1))
                               ? '0 : r_mean_wpos + 1'b1;
                if (r_mean_fill != MEAN_CW'(MEAN_TAPS)) r_mean_fill <= r_mean_fill + 1'b1;
            end

            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
                r_first     <= 1'b0;
                r_shown     <= disp;
                r_last_chg  <= r_chg;
                r_last_low  <= low;
            end else if (r_out_valid && !i_stall) begin
                // output register drains on a completed output transaction
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_adc <= i_adc_level;
                    r_chg <= i_charging;
                end
            end
            S_MAP: begin
                r_base <= seg_pct(seg);
                if (map_lo) r_raw <= '0;
                if (map_hi) r_raw <= PCT_MAX;
            end
            S_DIV_RAW: begin
                if (div_rsp.done) r_raw <= r_base + div_rsp.quo;
            end
            S_INS: begin
                r_med_win[r_med_wpos] <= r_raw;
                r_i      <= '0;
                r_j      <= '0;
                r_cnt_lt <= '0;
                r_cnt_le <= '0;
            end
            S_MED: begin
                if (med_row_end) begin
                    if (med_hit) r_med <= cand;
                    r_i      <= r_i + 1'b1;
                    r_j      <= '0;
                    r_cnt_lt <= '0;
                    r_cnt_le <= '0;
                end else begin
                    r_j      <= r_j + 1'b1;
                    r_cnt_lt <= cnt_lt_n;
                    r_cnt_le <= cnt_le_n;
                end
            end
            S_MINS: begin
                r_mean_win[r_mean_wpos] <= r_med;
                r_idx <= '0;
                r_sum <= '0;
            end
            S_SUM: begin
                r_sum <= r_sum + SUM_W'(r_mean_win[r_idx]);
                r_idx <= r_idx + 1'b1;
            end
            S_DIV_MEAN: begin
                if (div_rsp.done) r_filt <= div_rsp.quo;
            end
            S_OUT: begin
                if (out_free) begin
                    r_out_disp    <= disp;
                    r_out_filt    <= r_filt;
                    r_out_low     <= low;
                    r_out_changed <= changed;
                end
            end
            default: ;
        endcase
    end

    assign o_valid        = r_out_valid;
    assign o_display_pct  = r_out_disp;
    assign o_average_pct  = r_out_filt;
    assign o_low_battery  = r_out_low;
    assign o_changed      = r_out_changed;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    logic div_wait;
    logic fill_ok;
    logic pct_ok;

    // divider results only land while the sequencer waits on them
    assign div_wait = (r_state == S_DIV_RAW) || (r_state == S_DIV_MEAN);
    assign fill_ok  = (r_med_fill <= MED_CW'(MEDIAN_TAPS))
                      && (r_mean_fill <= MEAN_CW'(MEAN_TAPS));
    assign pct_ok   = (o_display_pct <= PCT_MAX) && (o_average_pct <= PCT_MAX);

`include "battery_level_filter_macros.svh"

    `BLF_ASSERT_NEXT(a_accept_maps, in_acc, r_state == S_MAP, "accept did not start mapping")
    `BLF_ASSERT_IMP(a_div_done_waited, div_rsp.done, div_wait, "divider done outside a wait")
    `BLF_ASSERT_ALWAYS(a_fill_bounds, fill_ok, "window fill out of range")
    `BLF_ASSERT_IMP(a_pct_range, o_valid, pct_ok, "result percentage above full")

endmodule
